>>> rtl/core/rc4_stream_cipher_unit_assert.svh
// Assertion macros shared by the RC4 core modules.
// Both expect clk and arst_n in the scope where they are used.
`ifndef RC4_STREAM_CIPHER_UNIT_ASSERT_SVH
`define RC4_STREAM_CIPHER_UNIT_ASSERT_SVH

// same-cycle implication
`define RC4_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RC4_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/rc4_pkg.sv
package rc4_pkg;

	localparam int BYTE_W        = 8;
	localparam int PERM_DEPTH    = 256;
	localparam int KEY_BYTES_MAX = 32;
	localparam int KEY_POS_W     = $clog2(KEY_BYTES_MAX);
	localparam int BYTE_SEL_W    = 3;
	localparam int KEY_WORDS     = KEY_BYTES_MAX / 8;
	localparam int KEY_WORD_SEL_W = $clog2(KEY_WORDS);
	localparam int KEY_LEN_W     = 6;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;

	typedef logic [BYTE_W-1:0]     byte_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [KEY_LEN_W-1:0]  key_len_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;

	localparam cfg_idx_t CFG_KEY_0_7    = 3'd0;
	localparam cfg_idx_t CFG_KEY_8_15   = 3'd1;
	localparam cfg_idx_t CFG_KEY_16_23  = 3'd2;
	localparam cfg_idx_t CFG_KEY_24_31  = 3'd3;
	localparam cfg_idx_t CFG_KEY_LENGTH = 3'd4;

	localparam key_len_t KEY_LEN_RESET = 6'd16;

	// input beat mode
	localparam logic MODE_KEY_SCHED = 1'b0;
	localparam logic MODE_CIPHER    = 1'b1;

	typedef enum logic [2:0] {
		ST_READY,
		ST_P2,
		ST_P3,
		ST_FILL,
		ST_KA,
		ST_KB,
		ST_KC,
		ST_KD
	} rc4_state_t;

	// controller -> datapath
	typedef struct packed {
		logic acc_byte;   // data beat taken: read S[i+1]
		logic ksa_start;  // key beat taken: clear schedule counters
		logic p2;         // read S[j]
		logic p3;         // write S[i], read S[t]
		logic fill;       // identity fill
		logic ka;         // schedule: read S[k]
		logic kb;         // schedule: update j, read S[j]
		logic kc;         // schedule: write S[k]
		logic kd;         // schedule: write S[j], advance k
		logic load_out;   // load output register
	} rc4_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic k_last;
	} rc4_stat_t;

endpackage

>>> rtl/core/rc4_ctrl.sv
`include "rc4_stream_cipher_unit_assert.svh"

module rc4_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             mode,
	output logic             out_valid,
	input  logic             out_stall,
	output rc4_pkg::rc4_cmd_t cmd,
	input  rc4_pkg::rc4_stat_t stat
);
	import rc4_pkg::*;

	rc4_state_t state_q, state_d;
	logic       res_pend_q, res_pend_d;
	logic       out_valid_q;
	logic       acc;
	logic       out_busy;

	assign out_busy = out_valid_q && out_stall;
	assign in_stall = (state_q != ST_READY) || (res_pend_q && out_busy);
	assign acc      = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_READY;
			res_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_pend_q  <= res_pend_d;
			out_valid_q <= cmd.load_out || out_busy;
		end
	end

	always_comb begin
		state_d    = state_q;
		res_pend_d = res_pend_q;
		cmd        = '0;
		unique case (state_q)
			ST_READY: begin
				if (res_pend_q && !out_busy) begin
					cmd.load_out = 1'b1;
					res_pend_d   = 1'b0;
				end
				if (acc) begin
					if (mode == MODE_CIPHER) begin
						cmd.acc_byte = 1'b1;
						state_d      = ST_P2;
					end else begin
						cmd.ksa_start = 1'b1;
						state_d       = ST_FILL;
					end
				end
			end
			ST_P2: begin
				cmd.p2  = 1'b1;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.p3     = 1'b1;
				res_pend_d = 1'b1;
				state_d    = ST_READY;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (stat.k_last) begin
					state_d = ST_KA;
				end
			end
			ST_KA: begin
				cmd.ka  = 1'b1;
				state_d = ST_KB;
			end
			ST_KB: begin
				cmd.kb  = 1'b1;
				state_d = ST_KC;
			end
			ST_KC: begin
				cmd.kc  = 1'b1;
				state_d = ST_KD;
			end
			ST_KD: begin
				cmd.kd  = 1'b1;
				state_d = stat.k_last ? ST_READY : ST_KA;
			end
		endcase
	end

	`RC4_ASSERT_NOW(a_pend_in_ready, res_pend_q, state_q == ST_READY, "pending off ready")
	`RC4_ASSERT_NEXT(a_p3_pend, state_q == ST_P3, res_pend_q && state_q == ST_READY, "no result")
	`RC4_ASSERT_NEXT(a_load_shows, cmd.load_out, out_valid_q, "loaded result not presented")

endmodule

>>> rtl/core/rc4_dp.sv
`include "rc4_stream_cipher_unit_assert.svh"

module rc4_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rc4_pkg::byte_t      data_byte,
	output rc4_pkg::byte_t      out_byte,
	input  logic                cfg_write,
	input  rc4_pkg::cfg_idx_t   cfg_index,
	input  rc4_pkg::cfg_data_t  cfg_data,
	input  rc4_pkg::rc4_cmd_t   cmd,
	output rc4_pkg::rc4_stat_t  stat
);
	import rc4_pkg::*;

	// permutation table, no reset
	byte_t perm_mem [PERM_DEPTH];

	// key registers
	cfg_data_t key_q [KEY_WORDS];
	key_len_t  key_len_q;
	key_len_t  key_len_eff;

	// stream and schedule state
	byte_t i_q, j_q, k_q, kj_q, si_q, data_q, out_byte_q;
	logic [KEY_POS_W-1:0] kpos_q;
	logic [KEY_POS_W:0]   kpos_inc;
	byte_t key_byte;

	// deferred swap write S[j] = S[i]
	logic  pend_valid_q;
	byte_t pend_addr_q, pend_data_q;

	// memory ports
	logic  mem_we, ra_en, rb_en;
	byte_t mem_waddr, mem_wdata, ra_addr, rb_addr;
	byte_t ra_mem_q, rb_mem_q;
	logic  ra_fwd_q, rb_fwd_q, rb_jhit_q;
	byte_t ra_fdata_q, rb_fdata_q, rb_jdata_q;
	byte_t ra_val, ks;
	byte_t j_nxt, kj_nxt, t_addr;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < KEY_WORDS; w++) begin
				key_q[w] <= '0;
			end
			key_len_q <= KEY_LEN_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_KEY_LENGTH) begin
				key_len_q <= cfg_data[KEY_LEN_W-1:0];
			end else if (cfg_index <= CFG_KEY_24_31) begin
				key_q[cfg_index[KEY_WORD_SEL_W-1:0]] <= cfg_data;
			end
		end
	end

	always_comb begin
		key_len_eff = key_len_q;
		if (key_len_q == '0) begin
			key_len_eff = key_len_t'(1);
		end else if (key_len_q > key_len_t'(KEY_BYTES_MAX)) begin
			key_len_eff = key_len_t'(KEY_BYTES_MAX);
		end
	end

	assign key_byte = key_q[kpos_q[KEY_POS_W-1:BYTE_SEL_W]][kpos_q[BYTE_SEL_W-1:0]*BYTE_W +: BYTE_W];
	assign kpos_inc = {1'b0, kpos_q} + (KEY_POS_W+1)'(1);

	// ---------------- table read data ----------------
	assign ra_val = ra_fwd_q ? ra_fdata_q : ra_mem_q;
	// keystream: S[i] was written in the read cycle, S[j] is still deferred
	assign ks     = rb_fwd_q ? rb_fdata_q : (rb_jhit_q ? rb_jdata_q : rb_mem_q);

	assign j_nxt  = byte_t'(j_q + ra_val);
	assign kj_nxt = byte_t'(kj_q + ra_val + key_byte);
	assign t_addr = byte_t'(si_q + ra_val);

	// ---------------- port steering ----------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pend_addr_q;
		mem_wdata = pend_data_q;
		priority if (cmd.fill) begin
			mem_we    = 1'b1;
			mem_waddr = k_q;
			mem_wdata = k_q;
		end else if (cmd.kc) begin
			mem_we    = 1'b1;
			mem_waddr = k_q;
			mem_wdata = ra_val;
		end else if (cmd.kd) begin
			mem_we    = 1'b1;
			mem_waddr = kj_q;
			mem_wdata = si_q;
		end else if (cmd.p3) begin
			mem_we    = 1'b1;
			mem_waddr = i_q;
			mem_wdata = ra_val;
		end else if (pend_valid_q) begin
			mem_we    = 1'b1;
		end else begin
			mem_we    = 1'b0;
		end
	end

	always_comb begin
		ra_en   = 1'b1;
		ra_addr = k_q;
		priority if (cmd.acc_byte) begin
			ra_addr = byte_t'(i_q + 8'd1);
		end else if (cmd.p2) begin
			ra_addr = j_nxt;
		end else if (cmd.kb) begin
			ra_addr = kj_nxt;
		end else if (cmd.ka) begin
			ra_addr = k_q;
		end else begin
			ra_en   = 1'b0;
		end
	end

	assign rb_en   = cmd.p3;
	assign rb_addr = t_addr;

	// ---------------- table ----------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			perm_mem[mem_waddr] <= mem_wdata;
		end
		if (ra_en) begin
			ra_mem_q   <= perm_mem[ra_addr];
			ra_fwd_q   <= mem_we && (mem_waddr == ra_addr);
			ra_fdata_q <= mem_wdata;
		end
		if (rb_en) begin
			rb_mem_q   <= perm_mem[rb_addr];
			rb_fwd_q   <= mem_we && (mem_waddr == rb_addr);
			rb_fdata_q <= mem_wdata;
			rb_jhit_q  <= (rb_addr == j_q);
			rb_jdata_q <= si_q;
		end
	end

	// ---------------- counters ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q          <= '0;
			j_q          <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			pend_valid_q <= cmd.p3;
			if (cmd.acc_byte) begin
				i_q <= byte_t'(i_q + 8'd1);
			end
			if (cmd.p2) begin
				j_q <= j_nxt;
			end
			if (cmd.kd && stat.k_last) begin
				i_q <= '0;
				j_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_byte) begin
			data_q <= data_byte;
		end
		if (cmd.p2) begin
			si_q <= ra_val;
		end
		if (cmd.p3) begin
			pend_addr_q <= j_q;
			pend_data_q <= si_q;
		end
		if (cmd.load_out) begin
			out_byte_q <= data_q ^ ks;
		end
		if (cmd.ksa_start) begin
			k_q    <= '0;
			kj_q   <= '0;
			kpos_q <= '0;
		end
		if (cmd.fill) begin
			k_q <= byte_t'(k_q + 8'd1);
		end
		if (cmd.kb) begin
			si_q <= ra_val;
			kj_q <= kj_nxt;
		end
		if (cmd.kd) begin
			k_q    <= byte_t'(k_q + 8'd1);
			kpos_q <= (kpos_inc >= key_len_eff) ? '0 : kpos_inc[KEY_POS_W-1:0];
		end
	end

	assign stat.k_last = (k_q == byte_t'(PERM_DEPTH - 1));
	assign out_byte    = out_byte_q;

	`RC4_ASSERT_NEXT(a_ksa_clears_idx, cmd.kd && stat.k_last, i_q == '0 && j_q == '0, "indices not cleared after schedule")

endmodule

>>> rtl/core/rc4_stream_cipher_unit.sv
// Data beat (mode 1): P2, P3, then an output register load; a new beat waits for P3 to end,
//   a pace set by the three table reads and two swap writes on the single-write-port table.
// Key beat (mode 0): busy for the identity fill and the key mixing over all 256 entries; no result.
// Reset: i/j counters cleared, key registers zero, key length 16; the permutation table keeps
//   no reset value and holds nothing usable until a key beat has run.
module rc4_stream_cipher_unit (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  rc4_pkg::byte_t     data_byte,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output rc4_pkg::byte_t     out_byte,
	// configuration write port
	input  logic               cfg_write,
	input  rc4_pkg::cfg_idx_t  cfg_index,
	input  rc4_pkg::cfg_data_t cfg_data
);
	import rc4_pkg::*;

	// Command bundle: one strobe per datapath step, decoded from the
	// controller state. The datapath reports back only the end of the
	// 256-entry sweeps used by fill and key mixing.
	rc4_cmd_t  cmd;
	rc4_stat_t stat;

	// Controller: sequences a data beat as
	//   take beat  - read S[i+1]; the previous deferred swap write is flushed on return to ready
	//   P2         - j += S[i], read S[j]
	//   P3         - write S[i] = S[j], read S[S[i]+S[j]], defer S[j] = S[i]
	// and loads the output register in the following ready cycle, which can
	// overlap taking the next beat. A result waiting on a stalled output holds
	// off the next beat.
	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: key registers, 256 x 8 permutation table (one write port,
	// two registered read ports with write-through forwarding), i/j counters,
	// key-schedule counters and the output register.
	rc4_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (data_byte),
		.out_byte  (out_byte),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

>>> bench/rc4_keystream_checker.sv
package rc4_tb_pkg;

	// busy time of a key beat (identity fill plus mixing)
	localparam int   KEY_SCHED_CYCLES = 1280;

endpackage

module rc4_keystream_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               mode,
	input  rc4_pkg::byte_t     data_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  rc4_pkg::byte_t     out_byte,
	input  logic               cfg_write,
	input  rc4_pkg::cfg_idx_t  cfg_index,
	input  rc4_pkg::cfg_data_t cfg_data,
	output int                 mismatch_count,
	output int                 pending_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;
	import rc4_tb_pkg::*;

	byte_t     perm [PERM_DEPTH];
	byte_t     ctr_i;
	byte_t     ctr_j;
	cfg_data_t key_word [KEY_WORDS];
	key_len_t  key_len;
	byte_t     expected_bytes [$];
	byte_t     want;

	function automatic void run_key_schedule();
		int unsigned len;
		int unsigned kpos;
		byte_t       j;
		byte_t       t;
		len = key_len;
		if (len == 0)
			len = 1;
		if (len > KEY_BYTES_MAX)
			len = KEY_BYTES_MAX;
		for (int k = 0; k < PERM_DEPTH; k++)
			perm[k] = byte_t'(k);
		j    = '0;
		kpos = 0;
		for (int k = 0; k < PERM_DEPTH; k++) begin
			j       = j + perm[k] + key_word[kpos / 8][8 * (kpos % 8) +: 8];
			t       = perm[k];
			perm[k] = perm[j];
			perm[j] = t;
			kpos    = (kpos + 1 >= len) ? 0 : kpos + 1;
		end
		ctr_i = '0;
		ctr_j = '0;
	endfunction

	function automatic byte_t cipher_step(byte_t din);
		byte_t t;
		byte_t ks_idx;
		ctr_i       = ctr_i + 8'd1;
		ctr_j       = ctr_j + perm[ctr_i];
		t           = perm[ctr_i];
		perm[ctr_i] = perm[ctr_j];
		perm[ctr_j] = t;
		ks_idx      = perm[ctr_i] + perm[ctr_j];
		return din ^ perm[ks_idx];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (perm[k])
				perm[k] = '0;
			foreach (key_word[w])
				key_word[w] = '0;
			key_len        = KEY_LEN_RESET;
			ctr_i          = '0;
			ctr_j          = '0;
			expected_bytes.delete();
			mismatch_count = 0;
			pending_bytes  = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_KEY_0_7, CFG_KEY_8_15, CFG_KEY_16_23, CFG_KEY_24_31:
						key_word[cfg_index[KEY_WORD_SEL_W-1:0]] = cfg_data;
					CFG_KEY_LENGTH:
						key_len = cfg_data[KEY_LEN_W-1:0];
					default: ;
				endcase
			end
			// output side first: a byte can never leave on the edge its beat enters
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: out_byte %02h arrived with no byte expected", $time,
						out_byte);
					mismatch_count++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want) begin
						$display("%0t: out_byte mismatch: expected %02h, got %02h", $time,
							want, out_byte);
						mismatch_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (mode == MODE_KEY_SCHED)
					run_key_schedule();
				else
					expected_bytes.push_back(cipher_step(data_byte));
			end
			pending_bytes = expected_bytes.size();
		end
	end

endmodule

>>> bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rc4_pkg::*;
	import rc4_tb_pkg::*;

	// hard stop, far beyond the slowest legal run
	localparam int       RUN_LIMIT_NS    = 2_000_000;
	localparam int       RANDOM_PHASES   = 8;
	localparam int       BEATS_PER_PHASE = 60;
	// indexes past the last register; writes there must be dropped
	localparam cfg_idx_t CFG_SPARE_FIRST = CFG_KEY_LENGTH + 3'd1;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      mode      = MODE_KEY_SCHED;
	byte_t     data_byte = '0;
	logic      out_stall = 1'b0;
	logic      cfg_write = 1'b0;
	cfg_idx_t  cfg_index = CFG_KEY_0_7;
	cfg_data_t cfg_data  = '0;
	logic      in_stall;
	logic      out_valid;
	byte_t     out_byte;

	int mismatch_count;
	int pending_bytes;

	// idling knobs, flipped per phase
	bit src_idle_on  = 1'b0;
	bit sink_idle_on = 1'b0;
	int stall_left   = 0;
	bit last_was_key = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	rc4_stream_cipher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.data_byte (data_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	rc4_keystream_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_bytes  (pending_bytes)
	);

	// Receiver backpressure: random stall bursts while enabled.
	// A burst in progress always runs out, even if the knob drops.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
			out_stall  <= 1'b1;
			stall_left = $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One input beat. Called at a falling edge, returns at the falling edge
	// after the beat is taken. Valid is left high so back-to-back beats
	// never see a low/high pair in one step; a gap lowers it first.
	task automatic send_beat(input logic m, input byte_t d);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_valid  <= 1'b1;
		mode      <= m;
		data_byte <= d;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		last_was_key = (m == MODE_KEY_SCHED);
	endtask

	// Drain to idle: every byte out, and a trailing key schedule given
	// time to finish since it shows nothing on the output.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_bytes != 0)
			@(negedge clk);
		if (last_was_key)
			repeat (KEY_SCHED_CYCLES + 16) @(negedge clk);
	endtask

	// write enable stays high across a burst of writes; caller lowers it
	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
	endtask

	// Full key setup, only ever from idle. Optional junk writes to the
	// unused indexes go last so any aliasing would clobber live regs.
	task automatic load_key(input cfg_data_t w0, input cfg_data_t w1, input cfg_data_t w2,
		input cfg_data_t w3, input cfg_data_t len_word, input bit spare_writes);
		settle();
		write_reg(CFG_KEY_0_7, w0);
		write_reg(CFG_KEY_8_15, w1);
		write_reg(CFG_KEY_16_23, w2);
		write_reg(CFG_KEY_24_31, w3);
		write_reg(CFG_KEY_LENGTH, len_word);
		if (spare_writes)
			for (int idx = int'(CFG_SPARE_FIRST); idx < (1 << CFG_IDX_W); idx++)
				write_reg(cfg_idx_t'(idx), {$urandom, $urandom});
		cfg_write <= 1'b0;
	endtask

	// mostly random words, with all-zero and all-one words mixed in
	function automatic cfg_data_t rand_key_word();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Length field: zero, one, max, past max, or typical. Upper bits of
	// the write word are garbage and must be ignored.
	function automatic cfg_data_t rand_len_word();
		cfg_data_t w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0:       w[KEY_LEN_W-1:0] = '0;
			1:       w[KEY_LEN_W-1:0] = key_len_t'(1);
			2:       w[KEY_LEN_W-1:0] = key_len_t'(KEY_BYTES_MAX);
			3:       w[KEY_LEN_W-1:0] = key_len_t'($urandom_range(KEY_BYTES_MAX + 1, 63));
			default: w[KEY_LEN_W-1:0] = key_len_t'($urandom_range(2, KEY_BYTES_MAX - 1));
		endcase
		return w;
	endfunction

	initial begin
		bit last_phase;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed ----
		// Reset key: all zero bytes, 16 long. First beat must be a key
		// beat, the table is garbage until one has run.
		send_beat(MODE_KEY_SCHED, 8'h00);
		send_beat(MODE_CIPHER, 8'h00);
		send_beat(MODE_CIPHER, 8'hFF);

		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;

		// length 0 acts as a one-byte key; junk at unused indexes;
		// the data field on a key beat is don't-care
		load_key(64'h0123_4567_89AB_CDEF, '0, '0, '0, '0, 1'b1);
		send_beat(MODE_KEY_SCHED, 8'hFF);
		send_beat(MODE_CIPHER, 8'hA5);
		send_beat(MODE_CIPHER, 8'h5A);

		// longest key, every bit set
		load_key('1, '1, '1, '1, cfg_data_t'(KEY_BYTES_MAX), 1'b0);
		send_beat(MODE_KEY_SCHED, 8'h00);
		send_beat(MODE_CIPHER, 8'h00);
		send_beat(MODE_CIPHER, 8'hFF);
		send_beat(MODE_CIPHER, 8'h80);
		send_beat(MODE_CIPHER, 8'h01);

		// top of the length field clamps to the max
		load_key(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word(),
			cfg_data_t'({KEY_LEN_W{1'b1}}), 1'b0);
		send_beat(MODE_KEY_SCHED, 8'h3C);
		send_beat(MODE_CIPHER, 8'hC3);
		send_beat(MODE_CIPHER, 8'h0F);
		send_beat(MODE_CIPHER, 8'hF0);

		// one past the max
		load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, cfg_data_t'(KEY_BYTES_MAX + 1), 1'b0);
		send_beat(MODE_KEY_SCHED, 8'h00);
		send_beat(MODE_CIPHER, 8'h12);
		send_beat(MODE_CIPHER, 8'hED);

		// back-to-back key beats; the second restarts from identity
		// and clears the counters again
		load_key(64'hFF, '0, '0, '0, cfg_data_t'(1), 1'b1);
		send_beat(MODE_KEY_SCHED, 8'h00);
		send_beat(MODE_KEY_SCHED, 8'hAA);
		send_beat(MODE_CIPHER, 8'h55);
		send_beat(MODE_CIPHER, 8'hAA);

		// ---- random ----
		// Each phase: fresh key, a key beat, then a long byte stream
		// with the odd rekey in the middle. Last phase runs at full rate.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			last_phase   = (p == RANDOM_PHASES - 1);
			src_idle_on  = !last_phase && ($urandom_range(0, 3) != 0);
			sink_idle_on = !last_phase && ($urandom_range(0, 3) != 0);
			load_key(rand_key_word(), rand_key_word(), rand_key_word(), rand_key_word(),
				rand_len_word(), $urandom_range(0, 3) == 0);
			send_beat(MODE_KEY_SCHED, byte_t'($urandom));
			for (int b = 0; b < BEATS_PER_PHASE; b++)
				send_beat(($urandom_range(0, 19) == 0) ? MODE_KEY_SCHED : MODE_CIPHER,
					byte_t'($urandom));
		end

		// ---- wrap up ----
		settle();
		repeat (16) @(negedge clk);
		if (mismatch_count == 0 && pending_bytes == 0)
			$display("** rc4_stream_cipher_unit: PASSED **");
		else
			$display("** rc4_stream_cipher_unit: FAILED **");
		$finish;
	end

	// watchdog: a hung handshake ends up here
	initial begin
		#(RUN_LIMIT_NS);
		$display("** rc4_stream_cipher_unit: FAILED **");
		$finish;
	end

endmodule
